/* hdl/block_range_add_range_sum_defines.svh */
// Assertion macros for the block range add and range sum engine.
`ifndef BLOCK_RANGE_ADD_RANGE_SUM_DEFINES_SVH
`define BLOCK_RANGE_ADD_RANGE_SUM_DEFINES_SVH

// check in the same cycle
`define BRS_ASSERT_IMP(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error(msg);

// check in the next cycle
`define BRS_ASSERT_NXT(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error(msg);

`endif

/* hdl/brs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, opcodes and sequencer states of the block range sum engine.
package brs_pkg;
	localparam int DEF_MAX_ELEMENTS = 4096;
	localparam int DEF_BLOCK_SIZE   = 64;
	localparam int DATA_W           = 64;
	localparam int OP_W             = 2;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_BAD   = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_LRD,
		ST_LOP,
		ST_LWR,
		ST_SEG_RD,
		ST_SEG_LD,
		ST_ERD,
		ST_EOP,
		ST_SEG_WR,
		ST_MRD,
		ST_MOP,
		ST_MACC,
		ST_DONE
	} state_t;
endpackage

/* hdl/block_range_add_range_sum.sv */
`timescale 1ns / 1ps
// Load: divide, then read, modify and write of the element and its block sum, then the done strobe.
// Add and query: divide, then each partial end block element by element, each whole block
// between them as one block step, then the done strobe; a bad request goes straight to done.
// One request at a time; busy stays high through the done strobe, next accept in the cycle after it.
// After reset a clearing pass zeroes all stores, busy held high.
// Results carry a one-cycle done strobe; the length register resets to MAX_ELEMENTS.
module block_range_add_range_sum import brs_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
	parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
	localparam int IDX_W       = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic [IDX_W-1:0]         first_index,
	input  logic [IDX_W-1:0]         last_index,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] range_sum,
	output logic                     status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_data
);
`include "block_range_add_range_sum_defines.svh"

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(BLOCK_SIZE);
	localparam int NB = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BW = (NB > 1) ? $clog2(NB) : 1;
	localparam logic [IDX_W-1:0] MAXI = IDX_W'(MAX_ELEMENTS);

	logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
	logic [DATA_W-1:0] sum_mem  [NB];
	logic [DATA_W-1:0] pend_mem [NB];

	state_t state_q, state_d;

	logic [IDX_W-1:0]  length_q;
	logic [AW-1:0]     clr_q;
	logic              go_q;
	logic [OP_W-1:0]   op_q;
	logic [AW-1:0]     lo_q, hi_q, e_q, eend_q, hstart_q;
	logic [BW-1:0]     cur_b_q, bh_q;
	logic              last_seg_q;
	logic              err_q;
	logic [DATA_W-1:0] v_q, acc_q, dsum_q, bsum_q, bpend_q, stored_q, old_q;
	logic [DATA_W-1:0] prod_s1, sumv_s1;
	logic [DATA_W-1:0] elem_rd_q, sum_rd_q, pend_rd_q;

	logic              div_done;
	logic [AW-1:0]     quo_a, quo_b;
	logic [CW-1:0]     rem_a, rem_b;

	logic              accept, req_ok;
	logic              elem_we, sum_we, pend_we;
	logic [AW-1:0]     elem_waddr, elem_raddr;
	logic [BW-1:0]     blk_waddr, blk_raddr;
	logic [DATA_W-1:0] elem_wdata, sum_wdata, pend_wdata;
	logic              clr_blk;

	brs_div #(.MAX_ELEMENTS(MAX_ELEMENTS), .BLOCK_SIZE(BLOCK_SIZE)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.num_a  (lo_q),
		.num_b  (hi_q),
		.done   (div_done),
		.quo_a  (quo_a),
		.rem_a  (rem_a),
		.quo_b  (quo_b),
		.rem_b  (rem_b)
	);

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = (state_q == ST_DONE);
	assign range_sum = acc_q;
	assign status    = err_q;
	assign clr_blk   = (clr_q < AW'(NB));

	always_comb begin
		req_ok = (first_index != '0) && (first_index <= length_q);
		if (op == OP_ADD || op == OP_QUERY) begin
			req_ok = req_ok && (last_index != '0) && (last_index <= length_q)
				&& (first_index <= last_index);
		end else if (op != OP_LOAD) begin
			req_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			length_q <= MAXI;
			clr_q    <= '0;
			go_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= accept && req_ok;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == '0) begin
					length_q <= IDX_W'(1);
				end else if (cfg_data > MAXI) begin
					length_q <= MAXI;
				end else begin
					length_q <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		elem_we    = 1'b0;
		sum_we     = 1'b0;
		pend_we    = 1'b0;
		elem_waddr = e_q;
		elem_raddr = e_q;
		blk_waddr  = cur_b_q;
		blk_raddr  = cur_b_q;
		elem_wdata = elem_rd_q + v_q;
		sum_wdata  = bsum_q + dsum_q;
		pend_wdata = pend_rd_q + v_q;
		case (state_q)
			ST_CLEAR: begin
				elem_we    = 1'b1;
				sum_we     = clr_blk;
				pend_we    = clr_blk;
				elem_waddr = clr_q;
				blk_waddr  = clr_q[BW-1:0];
				elem_wdata = '0;
				sum_wdata  = '0;
				pend_wdata = '0;
				if (clr_q == AW'(MAX_ELEMENTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = req_ok ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (op_q == OP_LOAD) ? ST_LRD : ST_SEG_RD;
				end
			end
			ST_LRD:    state_d = ST_LOP;
			ST_LOP:    state_d = ST_LWR;
			ST_LWR: begin
				elem_we    = 1'b1;
				sum_we     = 1'b1;
				elem_wdata = stored_q;
				sum_wdata  = bsum_q + stored_q - old_q;
				state_d    = ST_DONE;
			end
			ST_SEG_RD: state_d = ST_SEG_LD;
			ST_SEG_LD: state_d = ST_ERD;
			ST_ERD:    state_d = ST_EOP;
			ST_EOP: begin
				elem_we = (op_q == OP_ADD);
				state_d = (e_q == eend_q) ? ST_SEG_WR : ST_ERD;
			end
			ST_SEG_WR: begin
				sum_we = (op_q == OP_ADD);
				if (last_seg_q) begin
					state_d = ST_DONE;
				end else if (cur_b_q + 1'b1 == bh_q) begin
					state_d = ST_SEG_RD;
				end else begin
					state_d = ST_MRD;
				end
			end
			ST_MRD:    state_d = ST_MOP;
			ST_MOP: begin
				pend_we = (op_q == OP_ADD);
				state_d = ST_MACC;
			end
			ST_MACC: begin
				state_d = (cur_b_q + 1'b1 == bh_q) ? ST_SEG_RD : ST_MRD;
			end
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_waddr] <= elem_wdata;
		end
		elem_rd_q <= elem_mem[elem_raddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[blk_waddr] <= sum_wdata;
		end
		if (pend_we) begin
			pend_mem[blk_waddr] <= pend_wdata;
		end
		sum_rd_q  <= sum_mem[blk_raddr];
		pend_rd_q <= pend_mem[blk_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= op;
					v_q   <= value;
					lo_q  <= AW'(first_index - 1'b1);
					hi_q  <= AW'(last_index - 1'b1);
					acc_q <= '0;
					err_q <= !req_ok;
				end
			end
			ST_DIV: begin
				cur_b_q    <= quo_a[BW-1:0];
				bh_q       <= quo_b[BW-1:0];
				e_q        <= lo_q;
				hstart_q   <= hi_q - AW'(rem_b);
				last_seg_q <= (quo_a == quo_b) || (op_q == OP_LOAD);
				eend_q     <= (quo_a == quo_b) ? hi_q :
					AW'(lo_q + AW'(BLOCK_SIZE - 1) - AW'(rem_a));
			end
			ST_LOP: begin
				stored_q <= v_q - pend_rd_q;
				old_q    <= elem_rd_q;
				bsum_q   <= sum_rd_q;
			end
			ST_SEG_LD: begin
				bsum_q  <= sum_rd_q;
				bpend_q <= pend_rd_q;
				dsum_q  <= '0;
			end
			ST_EOP: begin
				if (op_q == OP_ADD) begin
					dsum_q <= dsum_q + v_q;
				end else begin
					acc_q <= acc_q + elem_rd_q + bpend_q;
				end
				e_q <= e_q + 1'b1;
			end
			ST_SEG_WR: begin
				if (!last_seg_q) begin
					cur_b_q <= cur_b_q + 1'b1;
					if (cur_b_q + 1'b1 == bh_q) begin
						e_q        <= hstart_q;
						eend_q     <= hi_q;
						last_seg_q <= 1'b1;
					end
				end
			end
			ST_MOP: begin
				prod_s1 <= DATA_W'(pend_rd_q * DATA_W'(BLOCK_SIZE));
				sumv_s1 <= sum_rd_q;
			end
			ST_MACC: begin
				if (op_q == OP_QUERY) begin
					acc_q <= acc_q + sumv_s1 + prod_s1;
				end
				cur_b_q <= cur_b_q + 1'b1;
				if (cur_b_q + 1'b1 == bh_q) begin
					e_q        <= hstart_q;
					eend_q     <= hi_q;
					last_seg_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	`BRS_ASSERT_NXT(a_done_one_cycle, done, !done, "done strobe longer than one cycle")
	`BRS_ASSERT_NXT(a_accept_busy, accept, busy, "request accepted without going busy")
	`BRS_ASSERT_IMP(a_err_zero_sum, done && status, range_sum == '0, "error with nonzero sum")
	`BRS_ASSERT_IMP(a_idle_no_write, state_q == ST_IDLE, !elem_we && !sum_we && !pend_we,
		"store written while idle")
endmodule

/* hdl/brs_div.sv */
`timescale 1ns / 1ps
// Registered divider of two element addresses by the block size, by reciprocal multiplication.
module brs_div import brs_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
	parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
	localparam int AW          = $clog2(MAX_ELEMENTS),
	localparam int CW          = $clog2(BLOCK_SIZE)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [AW-1:0] num_a,
	input  logic [AW-1:0] num_b,
	output logic          done,
	output logic [AW-1:0] quo_a,
	output logic [CW-1:0] rem_a,
	output logic [AW-1:0] quo_b,
	output logic [CW-1:0] rem_b
);
	localparam int SH = AW + CW;
	localparam int MW = AW + 2;
	localparam int PW = AW + MW;
	localparam int QW = AW + CW + 1;
	localparam longint RECIP = ((longint'(1) << SH) + longint'(BLOCK_SIZE) - longint'(1))
		/ longint'(BLOCK_SIZE);
	localparam logic [MW-1:0] MUL_C = MW'(RECIP);
	localparam logic [QW-1:0] BS_C  = QW'(BLOCK_SIZE);

	logic          go_s1;
	logic          done_q;
	logic [AW-1:0] na_s1, nb_s1, qa_s1, qb_s1;
	logic [CW-1:0] ra_q, rb_q;
	logic [PW-1:0] pa, pb;
	logic [QW-1:0] qda, qdb;

	always_comb begin
		pa  = PW'(num_a) * PW'(MUL_C);
		pb  = PW'(num_b) * PW'(MUL_C);
		qda = QW'(qa_s1) * BS_C;
		qdb = QW'(qb_s1) * BS_C;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_s1  <= go;
			done_q <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			na_s1 <= num_a;
			nb_s1 <= num_b;
			qa_s1 <= AW'(pa >> SH);
			qb_s1 <= AW'(pb >> SH);
		end
		if (go_s1) begin
			ra_q <= CW'(QW'(na_s1) - qda);
			rb_q <= CW'(QW'(nb_s1) - qdb);
		end
	end

	assign done  = done_q;
	assign quo_a = qa_s1;
	assign rem_a = ra_q;
	assign quo_b = qb_s1;
	assign rem_b = rb_q;
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the block range add and range sum engine.
module tb;
	import brs_pkg::*;

	localparam int MAXN  = DEF_MAX_ELEMENTS;
	localparam int BSZ   = DEF_BLOCK_SIZE;
	localparam int NBLK  = (MAXN + BSZ - 1) / BSZ;
	localparam int IDX_W = $clog2(MAXN + 1);
	localparam int WDOG  = 40000;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [DATA_W-1:0] val;
		logic              known;
		logic [DATA_W-1:0] sum;
		logic              st;
	} row_t;

	typedef struct {
		logic [DATA_W-1:0] sum;
		logic              st;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [OP_W-1:0] op = '0;
	logic [IDX_W-1:0] first_index = '0;
	logic [IDX_W-1:0] last_index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic done;
	logic signed [DATA_W-1:0] range_sum;
	logic status;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_data = '0;

	always #4 clk = ~clk;

	block_range_add_range_sum dut (.*);

	logic [DATA_W-1:0] elem_m [MAXN];
	logic [DATA_W-1:0] bsum_m [NBLK];
	logic [DATA_W-1:0] bpend_m [NBLK];
	logic [IDX_W-1:0] len_m;
	res_t sums_due[$];
	int errors = 0;
	int idle_cnt = 0;
	int send_idle = 0;

	function automatic logic [IDX_W-1:0] clamp_len(logic [IDX_W-1:0] w);
		if (w < 1) return IDX_W'(1);
		if (w > MAXN) return IDX_W'(MAXN);
		return w;
	endfunction

	function automatic res_t apply_request(logic [OP_W-1:0] o, logic [IDX_W-1:0] f,
			logic [IDX_W-1:0] l, logic [DATA_W-1:0] v);
		res_t r;
		int e, b;
		logic [DATA_W-1:0] stv;
		r.sum = '0;
		r.st = 0;
		if (o == OP_LOAD) begin
			if (f >= 1 && f <= len_m) begin
				e = f - 1;
				b = e / BSZ;
				stv = v - bpend_m[b];
				bsum_m[b] += stv - elem_m[e];
				elem_m[e] = stv;
			end else r.st = 1;
		end else if (o == OP_ADD || o == OP_QUERY) begin
			if (f >= 1 && f <= len_m && l >= 1 && l <= len_m && f <= l) begin
				for (int i = f - 1; i <= l - 1; i++) begin
					b = i / BSZ;
					if (o == OP_ADD) begin
						elem_m[i] += v;
						bsum_m[b] += v;
					end else r.sum += elem_m[i] + bpend_m[b];
				end
			end else r.st = 1;
		end else r.st = 1;
		return r;
	endfunction

	task automatic send_request(row_t rw);
		res_t r;
		r = apply_request(rw.op, rw.lo, rw.hi, rw.val);
		if (rw.known && (r.sum !== rw.sum || r.st !== rw.st)) begin
			errors++;
			if (errors <= 10)
				$display("table row mismatch op %0d: table %h/%0d model %h/%0d",
					rw.op, rw.sum, rw.st, r.sum, r.st);
		end
		sums_due.push_back(r);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		op <= rw.op;
		first_index <= rw.lo;
		last_index <= rw.hi;
		value <= rw.val;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 0;
		while (sums_due.size() != 0) @(posedge clk);
		while (n < 300) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_length(logic [IDX_W-1:0] w);
		drain();
		cfg_valid <= 1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		len_m = clamp_len(w);
	endtask

	always @(posedge clk) begin
		res_t x;
		if (arst_n) begin
			if (done) begin
				if (sums_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("result with none pending: %h/%0d",
						range_sum, status);
				end else begin
					x = sums_due.pop_front();
					if (range_sum !== x.sum || status !== x.st) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h/%0d got %h/%0d",
								x.sum, x.st, range_sum, status);
					end
				end
			end
			if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cnt <= 0;
			else idle_cnt <= idle_cnt + 1;
			if (idle_cnt > WDOG) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic row_t mk(logic [OP_W-1:0] o, int f, int l, logic [DATA_W-1:0] v);
		row_t r;
		r.op = o;
		r.lo = IDX_W'(f);
		r.hi = IDX_W'(l);
		r.val = v;
		r.known = 0;
		r.sum = '0;
		r.st = 0;
		return r;
	endfunction

	function automatic row_t mkk(logic [OP_W-1:0] o, int f, int l, logic [DATA_W-1:0] v,
			logic [DATA_W-1:0] s, logic st);
		row_t r;
		r = mk(o, f, l, v);
		r.known = 1;
		r.sum = s;
		r.st = st;
		return r;
	endfunction

	function automatic row_t rand_row();
		int f, l, k;
		row_t r;
		logic [DATA_W-1:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(3) == 0) v = $signed($urandom_range(200)) - 100;
		k = $urandom_range(99);
		if (len_m <= 1 || $urandom_range(3) != 0) begin
			f = $urandom_range(len_m, 1);
			l = $urandom_range(len_m, f);
			if ($urandom_range(4) == 0) l = (f + $urandom_range(10) > len_m) ? len_m
				: f + $urandom_range(10);
		end else begin
			f = $urandom_range(1, len_m);
			l = $urandom_range(1, len_m);
		end
		if (k < 5) begin
			f = $urandom_range(8191);
			l = $urandom_range(8191);
		end
		r = mk(k < 30 ? OP_LOAD : k < 60 ? OP_ADD : k < 97 ? OP_QUERY : OP_BAD, f, l, v);
		return r;
	endfunction

	initial begin
		row_t tbl[$];
		for (int i = 0; i < MAXN; i++) elem_m[i] = '0;
		for (int i = 0; i < NBLK; i++) begin
			bsum_m[i] = '0;
			bpend_m[i] = '0;
		end
		len_m = IDX_W'(MAXN);
		repeat (6) @(posedge clk);
		arst_n <= 1;
		tbl.push_back(mkk(OP_QUERY, 1, MAXN, 0, 0, 0));
		tbl.push_back(mkk(OP_LOAD, 1, 1, 64'h7fff_ffff_ffff_ffff, 0, 0));
		tbl.push_back(mkk(OP_LOAD, MAXN, 1, 64'h8000_0000_0000_0000, 0, 0));
		tbl.push_back(mkk(OP_QUERY, 1, 1, 0, 64'h7fff_ffff_ffff_ffff, 0));
		tbl.push_back(mkk(OP_QUERY, 1, MAXN, 0, 64'hffff_ffff_ffff_ffff, 0));
		tbl.push_back(mkk(OP_LOAD, 0, 0, 5, 0, 1));
		tbl.push_back(mkk(OP_LOAD, MAXN + 1, 0, 5, 0, 1));
		tbl.push_back(mkk(OP_LOAD, 8191, 8191, -1, 0, 1));
		tbl.push_back(mkk(OP_ADD, 5, 4, 1, 0, 1));
		tbl.push_back(mkk(OP_QUERY, 0, 3, 0, 0, 1));
		tbl.push_back(mkk(OP_QUERY, 1, MAXN + 1, 0, 0, 1));
		tbl.push_back(mkk(OP_BAD, 1, 1, 7, 0, 1));
		tbl.push_back(mk(OP_ADD, 1, MAXN, -1));
		tbl.push_back(mk(OP_ADD, 3, 60, 64'h1234_5678_9abc_def0));
		tbl.push_back(mk(OP_ADD, 60, 70, 3));
		tbl.push_back(mk(OP_LOAD, 65, 0, 11));
		tbl.push_back(mk(OP_QUERY, 2, 200, 0));
		tbl.push_back(mk(OP_QUERY, 64, 65, 0));
		tbl.push_back(mk(OP_QUERY, 1, MAXN, 0));
		foreach (tbl[i]) send_request(tbl[i]);
		write_length(0);
		send_request(mkk(OP_LOAD, 2, 0, 1, 0, 1));
		send_request(mk(OP_QUERY, 1, 1, 0));
		write_length(8191);
		send_request(mk(OP_QUERY, 4000, MAXN, 0));
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: send_idle = 0;
				1: send_idle = 65;
				2: send_idle = 0;
				default: send_idle = 10;
			endcase
			if (ph == 4) write_length(100);
			if (ph == 5) write_length(IDX_W'($urandom_range(MAXN, 1)));
			if (ph == 6) write_length(IDX_W'(MAXN));
			if (ph == 7) write_length(200);
			for (int n = 0; n < 125; n++) send_request(rand_row());
		end
		drain();
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
